/* src/s98csd_pkg.sv */
// shared types and constants for the s98 command stream decoder
// no dependencies; imported by every module of the block

package s98csd_pkg;

    localparam int MAX_VARINT_GROUPS = 4;
    localparam int GROUP_BITS        = 7;
    localparam int VARINT_W          = GROUP_BITS * MAX_VARINT_GROUPS;
    localparam int GROUP_CNT_W       = $clog2(MAX_VARINT_GROUPS + 1);
    localparam int TICK_W            = VARINT_W + 1;

    localparam int RATE_W  = 18;
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 16;
    localparam int WAIT_W  = 32;
    localparam int DEV_W   = 6;
    localparam int ADDR_W  = 9;
    localparam int DATA_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;

    localparam int PROD1_W = TICK_W + RATE_W;
    localparam int SPLIT_W = PROD1_W / 2;
    localparam int PROD_W  = PROD1_W + NUM_W;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] OP_WRITE_LIMIT = 8'h7F;
    localparam logic [BYTE_W-1:0] OP_WAIT_ONE    = 8'hFF;
    localparam logic [BYTE_W-1:0] OP_WAIT_VAR    = 8'hFE;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_NUM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DEN    = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
    localparam logic [NUM_W-1:0]  NUM_RESET  = 16'd10;
    localparam logic [DEN_W-1:0]  DEN_RESET  = 16'd1000;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_WAIT  = 2'd1,
        KIND_MARK  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [DEV_W-1:0]   device;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [TICK_W-1:0]  ticks;
    } cmd_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

/* src/s98csd_parser.sv */
// front end: classifies stream bytes and assembles commands
// one byte a cycle while the queue is not full; depends on s98csd_pkg

module s98csd_parser
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    input  logic [s98csd_pkg::BYTE_W-1:0]  byte_in,
    input  logic                           queue_full,
    output logic                           byte_ready,
    output logic                           push,
    output s98csd_pkg::cmd_t               push_cmd
);
    import s98csd_pkg::*;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_REG    = 2'd1,
        PH_DATA   = 2'd2,
        PH_VARINT = 2'd3
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [6:0]              dev_reg, dev_next;
    logic [DATA_W-1:0]       regb_reg, regb_next;
    logic [VARINT_W-1:0]     acc_reg, acc_next;
    logic [GROUP_CNT_W-1:0]  groups_reg, groups_next;
    logic                    accept;
    logic                    emit;
    cmd_t                    cmd;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign push       = accept && emit;
    assign push_cmd   = cmd;

    always_comb
    begin
        phase_next  = phase_reg;
        dev_next    = dev_reg;
        regb_next   = regb_reg;
        acc_next    = acc_reg;
        groups_next = groups_reg;
        emit        = 1'b0;
        cmd         = '0;
        unique case (phase_reg)
            PH_REG:
            begin
                regb_next  = byte_in;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                phase_next = PH_OPCODE;
                emit       = 1'b1;
                cmd.kind   = KIND_WRITE;
                cmd.device = dev_reg[6:1];
                cmd.addr   = {dev_reg[0], regb_reg};
                cmd.data   = byte_in;
            end
            PH_VARINT:
            begin
                if (groups_reg < GROUP_CNT_W'(MAX_VARINT_GROUPS))
                begin
                    for (int g = 0; g < MAX_VARINT_GROUPS; g++)
                    begin
                        if (groups_reg == GROUP_CNT_W'(g))
                        begin
                            acc_next[g*GROUP_BITS +: GROUP_BITS] = byte_in[GROUP_BITS-1:0];
                        end
                    end
                    groups_next = groups_reg + 1'b1;
                end
                if (!byte_in[BYTE_W-1])
                begin
                    phase_next = PH_OPCODE;
                    emit       = 1'b1;
                    cmd.kind   = KIND_WAIT;
                    cmd.ticks  = TICK_W'(acc_next) + TICK_W'(2);
                end
            end
            PH_OPCODE:
            begin
                if (byte_in < OP_WRITE_LIMIT)
                begin
                    dev_next   = byte_in[6:0];
                    phase_next = PH_REG;
                end
                else if (byte_in == OP_WAIT_ONE)
                begin
                    emit      = 1'b1;
                    cmd.kind  = KIND_WAIT;
                    cmd.ticks = TICK_W'(1);
                end
                else if (byte_in == OP_WAIT_VAR)
                begin
                    acc_next    = '0;
                    groups_next = '0;
                    phase_next  = PH_VARINT;
                end
                else
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_MARK;
                end
            end
            default:
            begin
                phase_next = PH_OPCODE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            dev_reg    <= '0;
            regb_reg   <= '0;
            acc_reg    <= '0;
            groups_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            dev_reg    <= dev_next;
            regb_reg   <= regb_next;
            acc_reg    <= acc_next;
            groups_reg <= groups_next;
        end
    end

endmodule

/* src/s98csd_queue.sv */
// short command queue between the parser and the sample converter
// depends on s98csd_pkg

module s98csd_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  s98csd_pkg::cmd_t               push_cmd,
    input  logic                           pop,
    output s98csd_pkg::cmd_t               head_cmd,
    output s98csd_pkg::queue_status_t      status
);
    import s98csd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/s98csd_samples.sv */
// back end: converts wait ticks to samples and drives the output register
// depends on s98csd_pkg; multiply split into steps and one-bit-a-cycle divide

module s98csd_samples
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  s98csd_pkg::cfg_t               cfg,
    input  s98csd_pkg::queue_status_t      q_status,
    input  s98csd_pkg::cmd_t               head_cmd,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output s98csd_pkg::cmd_t               out_cmd,
    output logic [s98csd_pkg::WAIT_W-1:0]  out_wait
);
    import s98csd_pkg::*;

    localparam int CNT_W  = $clog2(WAIT_W);
    localparam int HIGH_W = PROD_W - WAIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [PROD1_W-1:0]   mul_reg, mul_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [WAIT_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 valid_reg, valid_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;

    logic                 out_free;
    logic [PROD1_W-1:0]   prod_rate;
    logic [PROD_W-1:0]    prod_lo;
    logic [PROD_W-1:0]    prod_hi;
    logic [HIGH_W-1:0]    acc_high;
    logic [DEN_W:0]       trial;
    logic                 trial_ge;

    assign out_free  = !valid_reg || out_ready;
    assign prod_rate = PROD1_W'(tick_reg) * PROD1_W'(cfg.rate);
    assign prod_lo   = PROD_W'(mul_reg[SPLIT_W-1:0]) * PROD_W'(cfg.num);
    assign prod_hi   = PROD_W'(mul_reg[PROD1_W-1:SPLIT_W]) * PROD_W'(cfg.num);
    assign acc_high  = acc_reg[PROD_W-1:WAIT_W];
    assign trial     = {rem_reg, quo_reg[WAIT_W-1]};
    assign trial_ge  = (trial >= {1'b0, cfg.den});

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
    assign out_wait  = wait_reg;

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        mul_next   = mul_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        wait_next  = wait_reg;
        valid_next = valid_reg && !out_ready;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid && out_free)
                begin
                    pop = 1'b1;
                    if (head_cmd.kind == KIND_WAIT)
                    begin
                        tick_next  = head_cmd.ticks;
                        state_next = ST_MUL_RATE;
                    end
                    else
                    begin
                        cmd_next       = head_cmd;
                        cmd_next.ticks = '0;
                        wait_next      = '0;
                        valid_next     = 1'b1;
                    end
                end
            end
            ST_MUL_RATE:
            begin
                mul_next   = prod_rate;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                acc_next   = prod_lo;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                acc_next   = acc_reg + (prod_hi << SPLIT_W);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (cfg.den == '0 || acc_high >= HIGH_W'(cfg.den))
                begin
                    quo_next   = '1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = acc_reg[WAIT_W +: DEN_W];
                    quo_next   = acc_reg[WAIT_W-1:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? DEN_W'(trial - {1'b0, cfg.den}) : trial[DEN_W-1:0];
                quo_next = {quo_reg[WAIT_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WAIT_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd_next      = '0;
                    cmd_next.kind = KIND_WAIT;
                    wait_next     = quo_reg;
                    valid_next    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            tick_reg  <= '0;
            mul_reg   <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            cmd_reg   <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            tick_reg  <= tick_next;
            mul_reg   <= mul_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            cnt_reg   <= cnt_next;
            cmd_reg   <= cmd_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

/* src/s98_command_stream_decoder_top.sv */
// top level of the s98 command stream decoder: config registers and wiring
// depends on s98csd_pkg, s98csd_parser, s98csd_queue, s98csd_samples
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata[7:0] cmd_byte
// m_*       out  m_tvalid / m_tready    m_tuser kind, m_tdata device..wait_samples
// cfg_*     in   cfg_valid / cfg_ready  cfg_addr register index, cfg_data value
//
// one byte is taken per cycle while the four-entry command queue has room
// writes and markers go from the queue head straight into the output register
// a wait holds the converter through three multiply steps, a saturation check
// and a one-bit-a-cycle divide
// rst_n clears parser state, queue and output; config returns to 44100, 10, 1000
// a stalled output holds the converter, the queue then fills and s_tready drops

module s98_command_stream_decoder_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // cmd_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // device_index, reg_address,
                                                           // reg_data, wait_samples, zero pad
    output logic [1:0]                          m_tuser,   // kind
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [s98csd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [s98csd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import s98csd_pkg::*;

    cfg_t           cfg_reg;
    logic           push;
    cmd_t           push_cmd;
    logic           pop;
    cmd_t           head_cmd;
    queue_status_t  q_status;
    cmd_t           out_cmd;
    logic [WAIT_W-1:0] out_wait;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate <= RATE_RESET;
            cfg_reg.num  <= NUM_RESET;
            cfg_reg.den  <= DEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_SAMPLE_RATE: cfg_reg.rate <= cfg_data[RATE_W-1:0];
                CFG_TICK_NUM:    cfg_reg.num  <= cfg_data[NUM_W-1:0];
                CFG_TICK_DEN:    cfg_reg.den  <= cfg_data[DEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    s98csd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_in    (s_tdata),
        .queue_full (q_status.full),
        .byte_ready (s_tready),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    s98csd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    s98csd_samples u_samples
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cmd   (out_cmd),
        .out_wait  (out_wait)
    );

    assign m_tuser = out_cmd.kind;
    assign m_tdata = {1'b0, out_wait, out_cmd.data, out_cmd.addr, out_cmd.device};

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
        else $error("command pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_status.valid)
        else $error("command popped from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_MARK) |-> (m_tdata == '0))
        else $error("marker carries a nonzero payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_WAIT) |-> (m_tdata[22:0] == '0))
        else $error("wait carries register write fields");

endmodule

/* tb/s98_command_stream_decoder_checker.sv */
`timescale 1ns / 100ps
// checker for the s98 command stream decoder: follows the byte and config channels,
// predicts every decoded command and compares it with each output transaction
// depends on s98csd_pkg

module s98_command_stream_decoder_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [55:0]                        m_tdata,
    input  logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [s98csd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [s98csd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                 fail_count,
    output int                                 pending_cmds,
    output int                                 seen_writes,
    output int                                 seen_waits,
    output int                                 seen_marks
);
    import s98csd_pkg::*;

    typedef enum logic [1:0] {
        EXPECT_OPCODE,
        EXPECT_REG,
        EXPECT_DATA,
        IN_VARINT
    } parse_phase_t;

    typedef struct {
        kind_t              kind;
        logic [DEV_W-1:0]   device;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [WAIT_W-1:0]  samples;
    } decoded_cmd_t;

    decoded_cmd_t         expected_cmds[$];
    cfg_t                 cfg_shadow;
    parse_phase_t         phase;
    logic [6:0]           write_opcode;
    logic [7:0]           write_reg;
    logic [VARINT_W-1:0]  varint_value;
    int                   varint_count;

    function automatic logic [WAIT_W-1:0] ticks_to_samples(input logic [TICK_W-1:0] ticks);
        logic [63:0] product;
        logic [63:0] quotient;
        if (cfg_shadow.den == '0)
            return '1;
        // ticks < 2^29, rate < 2^18, num < 2^16: fits in 64 bits
        product  = 64'(ticks) * 64'(cfg_shadow.rate) * 64'(cfg_shadow.num);
        quotient = product / 64'(cfg_shadow.den);
        return (quotient > 64'hFFFF_FFFF) ? '1 : quotient[WAIT_W-1:0];
    endfunction

    function automatic void append_expected(input decoded_cmd_t cmd);
        expected_cmds.insert(expected_cmds.size(), cmd);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        decoded_cmd_t cmd;
        cmd = '{KIND_MARK, '0, '0, '0, '0};
        case (phase)
            EXPECT_REG:
            begin
                write_reg = b;
                phase     = EXPECT_DATA;
            end
            EXPECT_DATA:
            begin
                cmd.kind   = KIND_WRITE;
                cmd.device = write_opcode[6:1];
                cmd.addr   = {write_opcode[0], write_reg};
                cmd.data   = b;
                append_expected(cmd);
                phase = EXPECT_OPCODE;
            end
            IN_VARINT:
            begin
                // groups past the last one still chain, but their bits are dropped
                if (varint_count < MAX_VARINT_GROUPS)
                begin
                    varint_value = varint_value
                                 | (VARINT_W'(b[6:0]) << (GROUP_BITS * varint_count));
                    varint_count++;
                end
                if (!b[7])
                begin
                    cmd.kind    = KIND_WAIT;
                    cmd.samples = ticks_to_samples(TICK_W'(varint_value) + TICK_W'(2));
                    append_expected(cmd);
                    phase = EXPECT_OPCODE;
                end
            end
            default:
            begin
                if (b < OP_WRITE_LIMIT)
                begin
                    write_opcode = b[6:0];
                    phase        = EXPECT_REG;
                end
                else if (b == OP_WAIT_ONE)
                begin
                    cmd.kind    = KIND_WAIT;
                    cmd.samples = ticks_to_samples(TICK_W'(1));
                    append_expected(cmd);
                end
                else if (b == OP_WAIT_VAR)
                begin
                    varint_value = '0;
                    varint_count = 0;
                    phase        = IN_VARINT;
                end
                else
                    append_expected(cmd);
            end
        endcase
    endfunction

    function automatic void check_cmd(input logic [1:0] kind_bits, input logic [55:0] bus);
        decoded_cmd_t got;
        decoded_cmd_t want;
        got.kind    = kind_t'(kind_bits);
        got.device  = bus[5:0];
        got.addr    = bus[14:6];
        got.data    = bus[22:15];
        got.samples = bus[54:23];
        case (got.kind)
            KIND_WRITE: seen_writes++;
            KIND_WAIT:  seen_waits++;
            default:    seen_marks++;
        endcase
        if (expected_cmds.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected command kind %0d dev %0d addr %0h data %0h wait %0d",
                         $realtime, kind_bits, got.device, got.addr, got.data, got.samples);
            return;
        end
        want = expected_cmds.pop_front();
        if (kind_bits !== want.kind || got.device !== want.device || got.addr !== want.addr
            || got.data !== want.data || got.samples !== want.samples)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%0t: mismatch, expected kind %0d dev %0d addr %0h data %0h wait %0d",
                         $realtime, want.kind, want.device, want.addr, want.data, want.samples);
                $display("%0t:           got kind %0d dev %0d addr %0h data %0h wait %0d",
                         $realtime, kind_bits, got.device, got.addr, got.data, got.samples);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_cmds.delete();
            cfg_shadow   = '{RATE_RESET, NUM_RESET, DEN_RESET};
            phase        = EXPECT_OPCODE;
            write_opcode = '0;
            write_reg    = '0;
            varint_value = '0;
            varint_count = 0;
            fail_count   = 0;
            pending_cmds = 0;
            seen_writes  = 0;
            seen_waits   = 0;
            seen_marks   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_cmd(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    CFG_SAMPLE_RATE: cfg_shadow.rate = cfg_data[RATE_W-1:0];
                    CFG_TICK_NUM:    cfg_shadow.num  = cfg_data[NUM_W-1:0];
                    CFG_TICK_DEN:    cfg_shadow.den  = cfg_data[DEN_W-1:0];
                    default:         ;
                endcase
            end
            pending_cmds = expected_cmds.size();
        end
    end

endmodule

/* tb/s98_command_stream_decoder_top_test.sv */
`timescale 1ns / 100ps
// testbench top for the s98 command stream decoder: drives byte, config and output
// channels with directed and random command streams and reports the verdict
// depends on s98csd_pkg, s98_command_stream_decoder_top, s98_command_stream_decoder_checker

module s98_command_stream_decoder_top_test;

    import s98csd_pkg::*;

    localparam logic [BYTE_W-1:0]    OP_LOOP_END   = 8'hFD;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                   HOLD_CYCLES   = 300;
    localparam int                   SETTLE_CYCLES = 48;
    localparam int                   PHASE_BYTES   = 130;
    localparam int                   NUM_PHASES    = 9;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [55:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending_cmds;
    int seen_writes;
    int seen_waits;
    int seen_marks;
    int bytes_sent;
    int settings_used;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off_req;

    s98_command_stream_decoder_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    s98_command_stream_decoder_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_cmds (pending_cmds),
        .seen_writes  (seen_writes),
        .seen_waits   (seen_waits),
        .seen_marks   (seen_marks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random back-pressure, or one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
                m_tready <= !rx_idle_on || ($urandom_range(99) >= 33);
        end
    end

    task automatic send_cmd_byte(input logic [7:0] b);
        while (tx_idle_on && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_varint_wait(input int n_groups, input logic [6:0] group_bits);
        logic cont;
        send_cmd_byte(OP_WAIT_VAR);
        for (int i = 0; i < n_groups; i++)
        begin
            cont = (i != n_groups - 1);
            send_cmd_byte({cont, group_bits});
        end
    endtask

    task automatic send_random_command();
        int   pick;
        int   n_groups;
        logic cont;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            send_cmd_byte(8'($urandom_range(OP_WRITE_LIMIT - 1, 0)));
            send_cmd_byte(8'($urandom_range(255)));
            send_cmd_byte(8'($urandom_range(255)));
        end
        else if (pick < 65)
            send_cmd_byte(OP_WAIT_ONE);
        else if (pick < 82)
        begin
            pick     = $urandom_range(99);
            n_groups = (pick < 40) ? 1 : (pick < 65) ? 2 : (pick < 80) ? 3 :
                       (pick < 92) ? 4 : $urandom_range(7, 5);
            send_cmd_byte(OP_WAIT_VAR);
            for (int i = 0; i < n_groups; i++)
            begin
                cont = (i != n_groups - 1);
                send_cmd_byte({cont, 7'($urandom_range(127))});
            end
        end
        else if (pick < 92)
            send_cmd_byte(8'($urandom_range(OP_LOOP_END, OP_WRITE_LIMIT)));
        else
            send_cmd_byte(8'($urandom_range(255)));
    endtask

    task automatic stream_random_commands(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_random_command();
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_cmds != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] rate,
                            input logic [CFG_DATA_W-1:0] num,
                            input logic [CFG_DATA_W-1:0] den);
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_TICK_NUM, num);
        write_reg(CFG_TICK_DEN, den);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_off_req  = 1'b0;
        bytes_sent    = 0;
        settings_used = 1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unused register index must leave the settings alone
        write_reg(CFG_SPARE, '1);
        cfg_valid <= 1'b0;
        @(negedge clk);

        // reset settings: write extremes, every opcode class, short and long varints
        send_cmd_byte(8'h00); send_cmd_byte(8'h00); send_cmd_byte(8'h00);
        send_cmd_byte(8'(OP_WRITE_LIMIT - 1)); send_cmd_byte(8'hFF); send_cmd_byte(8'hFF);
        send_cmd_byte(8'h01); send_cmd_byte(8'h5A); send_cmd_byte(8'hA5);
        send_cmd_byte(OP_WRITE_LIMIT);
        send_cmd_byte(8'h80);
        send_cmd_byte(8'(OP_LOOP_END - 1));
        send_cmd_byte(OP_LOOP_END);
        send_cmd_byte(OP_WAIT_ONE);
        send_varint_wait(1, 7'h00);
        send_varint_wait(4, 7'h7F);
        send_varint_wait(6, 7'h55);
        wait_for_results();

        // product overflows 32 bits, then tiny ratio truncating to zero
        set_regs(18'h3FFFF, 18'h0FFFF, 18'd1);
        send_cmd_byte(OP_WAIT_ONE);
        send_varint_wait(4, 7'h7F);
        wait_for_results();
        set_regs(18'd1, 18'd1, 18'd65535);
        send_cmd_byte(OP_WAIT_ONE);
        send_varint_wait(4, 7'h7F);
        wait_for_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       set_regs(18'd44100, 18'd10, 18'd1000);
                1:       set_regs(18'h3FFFF, 18'h0FFFF, 18'd1);
                2:       set_regs(18'd0, 18'd10, 18'd1000);
                3:       set_regs(18'd44100, 18'd0, 18'd1000);
                4:       set_regs(18'd48000, 18'h2ABCD, 18'h30000);  // upper bits dropped
                5:       set_regs(18'd1, 18'd1, 18'd65535);
                default: set_regs(18'($urandom_range(192000, 1)),
                                  18'($urandom_range(65535, 1)),
                                  18'($urandom_range(65535, 1)));
            endcase
            tx_idle_on = (p != 6);
            rx_idle_on = (p != 6);
            if (p == 7)
                hold_off_req = 1'b1;
            stream_random_commands(PHASE_BYTES);
            wait_for_results();
        end

        $display("covered %0d stream bytes under %0d register settings, with a long output stall",
                 bytes_sent, settings_used);
        $display("checked %0d register writes, %0d waits, %0d loop/end markers",
                 seen_writes, seen_waits, seen_marks);
        if (fail_count == 0 && pending_cmds == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
